### rtl/srpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpm_pkg: shared types and constants of the sigmoid ramp position mover
// Word codes, register indexes, status codes and the Q16 sigmoid weight table.
// ----------------------------------------------------------------------------
package srpm_pkg;

   localparam int DATA_W  = 24;    // Q8 position and speed width
   localparam int BRAKE_W = 23;    // braking distance width
   localparam int TAB_W   = 6;     // sigmoid table address width
   localparam int WGT_W   = 17;    // Q16 weight, 65536 means 1.0

   typedef logic [1:0]         kind_type;
   typedef logic [1:0]         status_type;
   typedef logic [1:0]         csr_index_type;
   typedef logic [WGT_W-1:0]   weight_type;

   // word kinds
   localparam kind_type KIND_TICK  = 2'd0;
   localparam kind_type KIND_START = 2'd1;
   localparam kind_type KIND_SPEED = 2'd2;
   localparam kind_type KIND_STOP  = 2'd3;

   // result status
   localparam status_type STATUS_MOVING   = 2'd0;
   localparam status_type STATUS_DEADBAND = 2'd1;
   localparam status_type STATUS_FAULT    = 2'd2;
   localparam status_type STATUS_IDLE     = 2'd3;

   // register indexes
   localparam csr_index_type CSR_TARGET_POSITION  = 2'd0;
   localparam csr_index_type CSR_CRUISE_SPEED     = 2'd1;
   localparam csr_index_type CSR_BRAKING_DISTANCE = 2'd2;

   // 1/(1+exp(-(p-32)/4)) in Q16, last entry forced to 1.0
   function automatic weight_type sig_weight(input logic [TAB_W-1:0] pos);
      weight_type w;
      case (pos)
         6'd0:  w = 17'd22;     6'd1:  w = 17'd28;     6'd2:  w = 17'd36;
         6'd3:  w = 17'd47;     6'd4:  w = 17'd60;     6'd5:  w = 17'd77;
         6'd6:  w = 17'd98;     6'd7:  w = 17'd126;    6'd8:  w = 17'd162;
         6'd9:  w = 17'd208;    6'd10: w = 17'd267;    6'd11: w = 17'd342;
         6'd12: w = 17'd439;    6'd13: w = 17'd562;    6'd14: w = 17'd720;
         6'd15: w = 17'd922;    6'd16: w = 17'd1179;   6'd17: w = 17'd1506;
         6'd18: w = 17'd1921;   6'd19: w = 17'd2446;   6'd20: w = 17'd3108;
         6'd21: w = 17'd3938;   6'd22: w = 17'd4971;   6'd23: w = 17'd6249;
         6'd24: w = 17'd7812;   6'd25: w = 17'd9702;   6'd26: w = 17'd11955;
         6'd27: w = 17'd14595;  6'd28: w = 17'd17625;  6'd29: w = 17'd21025;
         6'd30: w = 17'd24743;  6'd31: w = 17'd28693;  6'd32: w = 17'd32768;
         6'd33: w = 17'd36843;  6'd34: w = 17'd40793;  6'd35: w = 17'd44511;
         6'd36: w = 17'd47911;  6'd37: w = 17'd50941;  6'd38: w = 17'd53581;
         6'd39: w = 17'd55834;  6'd40: w = 17'd57724;  6'd41: w = 17'd59287;
         6'd42: w = 17'd60565;  6'd43: w = 17'd61598;  6'd44: w = 17'd62428;
         6'd45: w = 17'd63090;  6'd46: w = 17'd63615;  6'd47: w = 17'd64030;
         6'd48: w = 17'd64357;  6'd49: w = 17'd64614;  6'd50: w = 17'd64816;
         6'd51: w = 17'd64974;  6'd52: w = 17'd65097;  6'd53: w = 17'd65194;
         6'd54: w = 17'd65269;  6'd55: w = 17'd65328;  6'd56: w = 17'd65374;
         6'd57: w = 17'd65410;  6'd58: w = 17'd65438;  6'd59: w = 17'd65459;
         6'd60: w = 17'd65476;  6'd61: w = 17'd65489;  6'd62: w = 17'd65500;
         default: w = 17'd65536;
      endcase
      return w;
   endfunction

endpackage

### rtl/sigmoid_ramp_position_mover_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sigmoid_ramp_position_mover_unit: joint position mover with sigmoid ramp
// Per tick: deadband stop, one-shot braking ramp, fault stop, else the speed
// command follows a tabled sigmoid from the ramp start toward the speed goal.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  req     | valid/ready, kind, measured_position,   | in
//          | new_speed, fault                        |
//  rsp     | valid/ready, drive, motor_stop, active, | out
//          | status                                  |
//  csr     | we, index, wdata                        | in
//
//  One word per cycle while rsp is not stalled. The error compare is done on
//  the way into the input register, the ramp multiply and state update on the
//  way into the result register, which feeds rsp.
//  Synchronous active-high reset clears the move state, the configuration registers and the valid flags.
//  A stalled rsp holds the result; the input register keeps taking words
//  as long as the result register frees up in the same cycle.
// ----------------------------------------------------------------------------
module sigmoid_ramp_position_mover_unit
   import srpm_pkg::*;
#(
   parameter int RAMP_STEPS  = 64,
   parameter int DEADBAND_Q8 = 128
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  kind_type                   req_kind,
   input  logic signed [DATA_W-1:0]   req_measured_position,
   input  logic signed [DATA_W-1:0]   req_new_speed,
   input  logic                       req_fault,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [DATA_W-1:0]   rsp_drive,
   output logic                       rsp_motor_stop,
   output logic                       rsp_active,
   output status_type                 rsp_status,
   // configuration
   input  logic                       csr_we,
   input  csr_index_type              csr_index,
   input  logic [DATA_W-1:0]          csr_wdata
);

   localparam int IDX_W = $clog2(RAMP_STEPS);
   localparam int POS_W = IDX_W + TAB_W;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RAMP_STEPS - 1);
   // table position index*64/RAMP_STEPS as a reciprocal multiply and shift,
   // exact for every numerator below 2**POS_W
   localparam int RCP_SH = POS_W + IDX_W;
   localparam logic [POS_W+1:0] RCP_MUL =
      (POS_W+2)'(((longint'(1) << RCP_SH) + RAMP_STEPS - 1) / RAMP_STEPS);

   // configuration registers
   logic signed [DATA_W-1:0]  target_position_ff;
   logic signed [DATA_W-1:0]  cruise_speed_ff;
   logic [BRAKE_W-1:0]        braking_distance_ff;

   // input register
   logic                      s1_valid_ff, s1_valid_in;
   kind_type                  s1_kind_ff;
   logic signed [DATA_W-1:0]  s1_new_speed_ff;
   logic                      s1_fault_ff;
   logic                      s1_dead_ff;
   logic                      s1_near_ff;

   // move state
   logic                      running_ff, running_in;
   logic                      braking_ff, braking_in;
   logic [IDX_W-1:0]          ramp_index_ff, ramp_index_in;
   logic signed [DATA_W-1:0]  ramp_start_ff, ramp_start_in;
   logic signed [DATA_W-1:0]  current_output_ff, current_output_in;
   logic signed [DATA_W-1:0]  speed_goal_ff, speed_goal_in;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]  rsp_drive_ff, rsp_drive_in;
   logic                      rsp_stop_ff, rsp_stop_in;
   logic                      rsp_active_ff, rsp_active_in;
   status_type                rsp_status_ff, rsp_status_in;

   logic                      s1_advance;
   logic                      req_take;

   // front-end error compare
   logic signed [DATA_W:0]    err;
   logic [DATA_W-1:0]         mag;

   // ramp datapath
   logic [IDX_W-1:0]          eff_index;
   logic signed [DATA_W-1:0]  eff_start;
   logic signed [DATA_W-1:0]  eff_goal;
   logic [2*POS_W+1:0]        pos_wide;
   weight_type                weight;
   logic signed [DATA_W:0]    diff;
   logic signed [DATA_W+WGT_W+1:0] prod;
   logic signed [DATA_W+WGT_W+1:0] prod_rnd;
   logic signed [DATA_W+2:0]  quot;
   logic signed [DATA_W+3:0]  ramp_sum;
   logic signed [DATA_W-1:0]  ramp_sat;
   logic                      brake_entry;

   // handshake: result register frees up, input register moves on
   assign s1_advance = !rsp_valid_ff || rsp_ready;
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_take   = req_valid && req_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_drive      = rsp_drive_ff;
   assign rsp_motor_stop = rsp_stop_ff;
   assign rsp_active     = rsp_active_ff;
   assign rsp_status     = rsp_status_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         target_position_ff  <= '0;
         cruise_speed_ff     <= '0;
         braking_distance_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TARGET_POSITION:  target_position_ff  <= $signed(csr_wdata);
            CSR_CRUISE_SPEED:     cruise_speed_ff     <= $signed(csr_wdata);
            CSR_BRAKING_DISTANCE: braking_distance_ff <= csr_wdata[BRAKE_W-1:0];
            default: ;
         endcase
      end
   end

   // position error magnitude against the target
   always_comb begin
      err = $signed({target_position_ff[DATA_W-1], target_position_ff})
          - $signed({req_measured_position[DATA_W-1], req_measured_position});
      mag = err[DATA_W] ? DATA_W'(-err) : err[DATA_W-1:0];
   end

   // capture word and compare flags
   assign s1_valid_in = req_take || (s1_valid_ff && !s1_advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_kind_ff      <= req_kind;
         s1_new_speed_ff <= req_new_speed;
         s1_fault_ff     <= req_fault;
         s1_dead_ff      <= (mag < DATA_W'(DEADBAND_Q8));
         s1_near_ff      <= (mag < {1'b0, braking_distance_ff});
      end
   end

   // braking entry swaps in a fresh ramp toward zero before the ramp step
   assign brake_entry = !braking_ff && s1_near_ff;

   always_comb begin
      eff_index = brake_entry ? '0 : ramp_index_ff;
      eff_start = brake_entry ? current_output_ff : ramp_start_ff;
      eff_goal  = brake_entry ? '0 : speed_goal_ff;
   end

   // sigmoid step: start + round((goal - start) * w / 65536), saturated
   always_comb begin
      pos_wide = {eff_index, {TAB_W{1'b0}}} * RCP_MUL;
      weight   = sig_weight(pos_wide[RCP_SH +: TAB_W]);
      diff     = $signed({eff_goal[DATA_W-1], eff_goal})
               - $signed({eff_start[DATA_W-1], eff_start});
      prod     = diff * $signed({1'b0, weight});
      prod_rnd = prod + (DATA_W+WGT_W+2)'(32768);
      quot     = prod_rnd[DATA_W+WGT_W+1:16];
      ramp_sum = $signed({{4{eff_start[DATA_W-1]}}, eff_start})
               + $signed({quot[DATA_W+2], quot});
      if (ramp_sum > $signed((DATA_W+4)'(8388607))) begin
         ramp_sat = 24'sh7FFFFF;
      end else if (ramp_sum < -$signed((DATA_W+4)'(8388608))) begin
         ramp_sat = 24'sh800000;
      end else begin
         ramp_sat = ramp_sum[DATA_W-1:0];
      end
   end

   // next state and result for the word in the input register
   always_comb begin
      running_in        = running_ff;
      braking_in        = braking_ff;
      ramp_index_in     = ramp_index_ff;
      ramp_start_in     = ramp_start_ff;
      current_output_in = current_output_ff;
      speed_goal_in     = speed_goal_ff;
      rsp_drive_in      = current_output_ff;
      rsp_stop_in       = 1'b0;
      rsp_active_in     = 1'b0;
      rsp_status_in     = STATUS_IDLE;

      case (s1_kind_ff)
         KIND_START: begin
            running_in    = 1'b1;
            braking_in    = 1'b0;
            ramp_index_in = '0;
            ramp_start_in = current_output_ff;
            speed_goal_in = cruise_speed_ff;
            rsp_active_in = 1'b1;
            rsp_status_in = STATUS_MOVING;
         end
         KIND_SPEED: begin
            ramp_start_in = current_output_ff;
            speed_goal_in = s1_new_speed_ff;
            ramp_index_in = '0;
            braking_in    = 1'b0;
            rsp_active_in = running_ff;
            rsp_status_in = running_ff ? STATUS_MOVING : STATUS_IDLE;
         end
         KIND_STOP: begin
            running_in = 1'b0;
         end
         default: begin
            if (running_ff) begin
               if (s1_dead_ff) begin
                  // reached: stop, keep the output register
                  running_in    = 1'b0;
                  rsp_drive_in  = '0;
                  rsp_stop_in   = 1'b1;
                  rsp_status_in = STATUS_DEADBAND;
               end else begin
                  if (brake_entry) begin
                     braking_in    = 1'b1;
                     ramp_start_in = current_output_ff;
                     speed_goal_in = '0;
                     ramp_index_in = '0;
                  end
                  if (s1_fault_ff) begin
                     running_in    = 1'b0;
                     rsp_drive_in  = '0;
                     rsp_stop_in   = 1'b1;
                     rsp_status_in = STATUS_FAULT;
                  end else begin
                     // advance the ramp, index stops at the last step
                     current_output_in = ramp_sat;
                     ramp_index_in     = (eff_index == IDX_LAST) ? IDX_LAST
                                                                 : eff_index + 1'b1;
                     rsp_drive_in      = ramp_sat;
                     rsp_active_in     = 1'b1;
                     rsp_status_in     = STATUS_MOVING;
                  end
               end
            end
         end
      endcase
   end

   // result register and move state advance together
   assign rsp_valid_in = (s1_valid_ff && s1_advance) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff      <= 1'b0;
         running_ff        <= 1'b0;
         braking_ff        <= 1'b0;
         ramp_index_ff     <= '0;
         ramp_start_ff     <= '0;
         current_output_ff <= '0;
         speed_goal_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (s1_valid_ff && s1_advance) begin
            running_ff        <= running_in;
            braking_ff        <= braking_in;
            ramp_index_ff     <= ramp_index_in;
            ramp_start_ff     <= ramp_start_in;
            current_output_ff <= current_output_in;
            speed_goal_ff     <= speed_goal_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_advance) begin
         rsp_drive_ff  <= rsp_drive_in;
         rsp_stop_ff   <= rsp_stop_in;
         rsp_active_ff <= rsp_active_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

endmodule

### rtl/srpm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpm_checker: port-level checks of the position mover
// Watches the response channel for consistent stop, active and status codes.
// ----------------------------------------------------------------------------
module srpm_checker
   import srpm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic signed [DATA_W-1:0]   rsp_drive,
   input  logic                       rsp_motor_stop,
   input  logic                       rsp_active,
   input  status_type                 rsp_status
);

   // a stop word ends the move and commands zero drive
   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_motor_stop |-> !rsp_active && (rsp_drive == '0))
      else $error("stop word with nonzero drive or active move");

   // a stop word reports a deadband or fault reason
   a_stop_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_motor_stop |->
         (rsp_status == STATUS_DEADBAND) || (rsp_status == STATUS_FAULT))
      else $error("stop word without stop reason");

   // active flag and moving status never disagree
   a_active_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_active == (rsp_status == STATUS_MOVING)))
      else $error("active flag disagrees with status");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive)
         && $stable(rsp_status))
      else $error("stalled result changed");

endmodule

bind sigmoid_ramp_position_mover_unit srpm_checker u_srpm_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_drive      (rsp_drive),
   .rsp_motor_stop (rsp_motor_stop),
   .rsp_active     (rsp_active),
   .rsp_status     (rsp_status)
);

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the sigmoid ramp position mover
// Drives request words in random bursts against a stalling response side and
// checks every response word against a cycle-free motion predictor kept here.
// A short directed list covers idle words, extremes, deadband, braking and
// fault stops. Random phases follow, each with its own register setting.
// Random words are mostly whole moves: start, ticks closing in on the target,
// the odd speed change, and either a stop or fault or a deadband landing.
// ----------------------------------------------------------------------------
module testbench;
   import srpm_pkg::*;

   localparam int RAMP_STEPS  = 64;
   localparam int DEADBAND_Q8 = 128;
   localparam int TAB_LEN     = 64;
   localparam int HALF_PERIOD = 5;
   localparam int CYCLE_LIMIT = 500000;
   localparam int PHASE_WORDS = 230;
   localparam int POS_MAX     = 8388607;
   localparam int POS_MIN     = -8388608;

   // index with no register behind it
   localparam csr_index_type CSR_UNMAPPED = 2'd3;

   typedef struct packed {
      logic [DATA_W-1:0] drive;
      logic              motor_stop;
      logic              active;
      status_type        status;
   } motion_result_type;

   typedef struct packed {
      kind_type          kind;
      logic [DATA_W-1:0] position;
      logic [DATA_W-1:0] speed;
      logic              fault;
      logic              has_literal;
      motion_result_type literal;
   } stim_word_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   kind_type                 req_kind = KIND_TICK;
   logic signed [DATA_W-1:0] req_measured_position = '0;
   logic signed [DATA_W-1:0] req_new_speed = '0;
   logic                     req_fault = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b1;
   logic signed [DATA_W-1:0] rsp_drive;
   logic                     rsp_motor_stop;
   logic                     rsp_active;
   status_type               rsp_status;
   logic                     csr_we = 1'b0;
   csr_index_type            csr_index = CSR_TARGET_POSITION;
   logic [DATA_W-1:0]        csr_wdata = '0;

   // literal expectation that travels with the word on the bus
   logic                     lit_valid = 1'b0;
   motion_result_type        lit_result = '0;

   // predictor registers and move state
   logic signed [DATA_W-1:0] cfg_target = '0;
   logic signed [DATA_W-1:0] cfg_cruise = '0;
   logic [BRAKE_W-1:0]       cfg_brake = '0;
   logic                     mv_running = 1'b0;
   logic                     mv_braking = 1'b0;
   int                       ramp_step = 0;
   logic signed [DATA_W-1:0] ramp_origin = '0;
   logic signed [DATA_W-1:0] drive_now = '0;
   logic signed [DATA_W-1:0] speed_target = '0;

   int sigmoid_q16 [TAB_LEN] = '{
      22, 28, 36, 47, 60, 77, 98, 126,
      162, 208, 267, 342, 439, 562, 720, 922,
      1179, 1506, 1921, 2446, 3108, 3938, 4971, 6249,
      7812, 9702, 11955, 14595, 17625, 21025, 24743, 28693,
      32768, 36843, 40793, 44511, 47911, 50941, 53581, 55834,
      57724, 59287, 60565, 61598, 62428, 63090, 63615, 64030,
      64357, 64614, 64816, 64974, 65097, 65194, 65269, 65328,
      65374, 65410, 65438, 65459, 65476, 65489, 65500, 65536
   };

   motion_result_type expected_motion_q [$];
   int             error_count = 0;
   int             cycle_count = 0;
   int             burst_left = 0;
   bit             gap_mode = 1'b1;
   int             ready_mode = 0;

   sigmoid_ramp_position_mover_unit #(
      .RAMP_STEPS  (RAMP_STEPS),
      .DEADBAND_Q8 (DEADBAND_Q8)
   ) i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_kind              (req_kind),
      .req_measured_position (req_measured_position),
      .req_new_speed         (req_new_speed),
      .req_fault             (req_fault),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_drive             (rsp_drive),
      .rsp_motor_stop        (rsp_motor_stop),
      .rsp_active            (rsp_active),
      .rsp_status            (rsp_status),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // count cycles and stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // next point on the sigmoid from the ramp origin toward the speed target
   function automatic logic [DATA_W-1:0] next_drive();
      int     slot;
      longint delta;
      longint acc;
      longint level;
      slot = ramp_step * TAB_LEN / RAMP_STEPS;
      if (slot >= TAB_LEN) slot = TAB_LEN - 1;
      delta = longint'(speed_target) - longint'(ramp_origin);
      acc   = delta * longint'(sigmoid_q16[slot]) + 64'sd32768;
      level = longint'(ramp_origin) + (acc >>> 16);
      if (level > POS_MAX) level = POS_MAX;
      else if (level < POS_MIN) level = POS_MIN;
      return level[DATA_W-1:0];
   endfunction

   // advance the move state by one word and return the response it causes
   function automatic motion_result_type predict_motion(input kind_type kind,
                                                        input logic [DATA_W-1:0] position,
                                                        input logic [DATA_W-1:0] speed,
                                                        input logic fault);
      motion_result_type r;
      int             err;
      int             mag;
      r.drive      = drive_now;
      r.motor_stop = 1'b0;
      r.active     = 1'b0;
      r.status     = STATUS_IDLE;
      case (kind)
         KIND_START: begin
            mv_running   = 1'b1;
            mv_braking   = 1'b0;
            ramp_step    = 0;
            ramp_origin  = drive_now;
            speed_target = cfg_cruise;
            r.active     = 1'b1;
            r.status     = STATUS_MOVING;
         end
         KIND_SPEED: begin
            ramp_origin  = drive_now;
            speed_target = speed;
            ramp_step    = 0;
            mv_braking   = 1'b0;
            r.active     = mv_running;
            r.status     = mv_running ? STATUS_MOVING : STATUS_IDLE;
         end
         KIND_STOP: begin
            mv_running = 1'b0;
         end
         default: begin
            if (mv_running) begin
               err = int'(cfg_target) - int'($signed(position));
               mag = (err < 0) ? -err : err;
               if (mag < DEADBAND_Q8) begin
                  mv_running   = 1'b0;
                  r.drive      = '0;
                  r.motor_stop = 1'b1;
                  r.status     = STATUS_DEADBAND;
               end else begin
                  // braking entry comes ahead of the fault check
                  if (!mv_braking && mag < int'(cfg_brake)) begin
                     mv_braking   = 1'b1;
                     ramp_origin  = drive_now;
                     speed_target = '0;
                     ramp_step    = 0;
                  end
                  if (fault) begin
                     mv_running   = 1'b0;
                     r.drive      = '0;
                     r.motor_stop = 1'b1;
                     r.status     = STATUS_FAULT;
                  end else begin
                     drive_now = next_drive();
                     if (ramp_step < RAMP_STEPS - 1) ramp_step++;
                     r.drive  = drive_now;
                     r.active = 1'b1;
                     r.status = STATUS_MOVING;
                  end
               end
            end
         end
      endcase
      return r;
   endfunction

   // check responses, then log what each accepted request will produce
   always @(posedge clock) begin
      motion_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_motion_q.size() == 0) begin
               $error("response word with nothing pending: drive %0d status %0d",
                      rsp_drive, rsp_status);
               error_count++;
            end else begin
               want = expected_motion_q.pop_front();
               if (want.drive !== rsp_drive) begin
                  $error("drive mismatch: expected %0d, got %0d",
                         $signed(want.drive), rsp_drive);
                  error_count++;
               end
               if (want.motor_stop !== rsp_motor_stop) begin
                  $error("motor_stop mismatch: expected %0b, got %0b",
                         want.motor_stop, rsp_motor_stop);
                  error_count++;
               end
               if (want.active !== rsp_active) begin
                  $error("active mismatch: expected %0b, got %0b", want.active, rsp_active);
                  error_count++;
               end
               if (want.status !== rsp_status) begin
                  $error("status mismatch: expected %0d, got %0d", want.status, rsp_status);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            want = predict_motion(req_kind, req_measured_position, req_new_speed, req_fault);
            if (lit_valid) want = lit_result;
            expected_motion_q.push_back(want);
         end
      end
   end

   // response stalls in one of four random patterns
   always @(negedge clock) begin
      if (cycle_count % 200 == 0) ready_mode = $urandom_range(0, 3);
      case (ready_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= ($urandom_range(0, 9) < 7);
         2:       rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= (cycle_count % 5 == 0);
      endcase
   end

   // hold valid low and scramble the payload
   task automatic idle_for(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid             <= 1'b0;
         req_kind              <= kind_type'($urandom_range(0, 3));
         req_measured_position <= DATA_W'($urandom);
         req_new_speed         <= DATA_W'($urandom);
         req_fault             <= 1'($urandom);
         lit_valid             <= 1'b0;
      end
   endtask

   // present one word and wait for it to be taken
   task automatic send_word(input stim_word_type w);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (gap_mode)
            idle_for(($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                 : $urandom_range(1, 5));
      end
      burst_left--;
      @(negedge clock);
      req_valid             <= 1'b1;
      req_kind              <= w.kind;
      req_measured_position <= w.position;
      req_new_speed         <= w.speed;
      req_fault             <= w.fault;
      lit_valid             <= w.has_literal;
      lit_result            <= w.literal;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // write one register and mirror it in the predictor
   task automatic write_csr(input csr_index_type idx, input logic [DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_TARGET_POSITION:  cfg_target = data;
         CSR_CRUISE_SPEED:     cfg_cruise = data;
         CSR_BRAKING_DISTANCE: cfg_brake  = data[BRAKE_W-1:0];
         default: ;
      endcase
   endtask

   // drain: drop valid, wait for every response, then cover the pipeline
   task automatic settle();
      idle_for(1);
      while (expected_motion_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   function automatic stim_word_type dir_word(input kind_type k, input int pos,
                                              input int spd, input bit flt, input bit lit,
                                              input int drv, input bit stp, input bit act,
                                              input status_type st);
      stim_word_type w;
      w.kind               = k;
      w.position           = DATA_W'(pos);
      w.speed              = DATA_W'(spd);
      w.fault              = flt;
      w.has_literal        = lit;
      w.literal.drive      = DATA_W'(drv);
      w.literal.motor_stop = stp;
      w.literal.active     = act;
      w.literal.status     = st;
      return w;
   endfunction

   // random moves toward the current target, mixed with noise words
   task automatic run_phase(input int n_words);
      int            sent;
      int            len;
      int            d0;
      int            span;
      int            off;
      int            pos;
      int            i;
      int            e;
      int            tgt;
      stim_word_type w;
      sent = 0;
      tgt  = int'(cfg_target);
      span = int'(cfg_brake) * 2 + 4096;
      if (span > POS_MAX) span = POS_MAX;
      while (sent < n_words) begin
         w = '0;
         if ($urandom_range(0, 99) < 35) begin
            // noise: any kind, any payload
            repeat ($urandom_range(1, 12)) begin
               w.kind     = kind_type'($urandom_range(0, 3));
               w.position = DATA_W'($urandom);
               w.speed    = DATA_W'($urandom);
               w.fault    = 1'($urandom);
               send_word(w);
               sent++;
            end
         end else begin
            if ($urandom_range(0, 19) == 0) begin
               w.kind  = KIND_SPEED;
               w.speed = DATA_W'($urandom);
               send_word(w);
               sent++;
               w = '0;
            end
            w.kind = KIND_START;
            send_word(w);
            sent++;
            len = $urandom_range(4, 100);
            d0  = ($urandom_range(0, 9) == 0) ? int'($signed(DATA_W'($urandom)))
                                              : int'($urandom_range(0, 2 * span)) - span;
            for (i = 0; i < len; i++) begin
               w      = '0;
               w.kind = KIND_TICK;
               // close in on the target, land in the deadband on the last tick
               if (i == len - 1)
                  off = int'($urandom_range(0, 254)) - 127;
               else
                  off = int'(longint'(d0) * (len - 1 - i) / (len - 1))
                        + int'($urandom_range(0, 80)) - 40;
               pos = tgt + off;
               if (pos > POS_MAX) pos = POS_MAX;
               else if (pos < POS_MIN) pos = POS_MIN;
               w.position = DATA_W'(pos);
               e = $urandom_range(0, 99);
               if (e < 3) w.fault = 1'b1;
               else if (e < 6) begin
                  w.kind  = KIND_SPEED;
                  w.speed = DATA_W'($urandom);
               end else if (e < 8) w.kind = KIND_STOP;
               else if (e < 10) w.kind = KIND_START;
               send_word(w);
               sent++;
               if (w.fault || w.kind == KIND_STOP) break;
            end
         end
      end
   endtask

   initial begin
      stim_word_type rows [25];
      int            i;
      int            p;
      int            tgt;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part: target 100 deg, cruise 10 deg/s, braking 20 deg
      tgt = 25600;
      write_csr(CSR_TARGET_POSITION, DATA_W'(tgt));
      write_csr(CSR_CRUISE_SPEED, DATA_W'(2560));
      write_csr(CSR_BRAKING_DISTANCE, DATA_W'(5120));

      rows[0]  = dir_word(KIND_TICK,  0, 0, 0, 1, 0, 0, 0, STATUS_IDLE);
      rows[1]  = dir_word(KIND_STOP,  0, 0, 0, 1, 0, 0, 0, STATUS_IDLE);
      rows[2]  = dir_word(KIND_SPEED, 0, POS_MAX, 0, 1, 0, 0, 0, STATUS_IDLE);
      rows[3]  = dir_word(KIND_START, 0, 0, 0, 1, 0, 0, 1, STATUS_MOVING);
      rows[4]  = dir_word(KIND_TICK,  POS_MIN, 0, 0, 0, 0, 0, 0, STATUS_IDLE);
      rows[5]  = dir_word(KIND_TICK,  POS_MAX, 0, 0, 0, 0, 0, 0, STATUS_IDLE);
      rows[6]  = dir_word(KIND_SPEED, 0, POS_MAX, 0, 0, 0, 0, 0, STATUS_IDLE);
      rows[7]  = dir_word(KIND_TICK,  0, 0, 0, 0, 0, 0, 0, STATUS_IDLE);
      rows[8]  = dir_word(KIND_TICK,  0, 0, 0, 0, 0, 0, 0, STATUS_IDLE);
      rows[9]  = dir_word(KIND_TICK,  0, 0, 0, 0, 0, 0, 0, STATUS_IDLE);
      rows[10] = dir_word(KIND_SPEED, 0, POS_MIN, 0, 0, 0, 0, 0, STATUS_IDLE);
      rows[11] = dir_word(KIND_TICK,  0, 0, 0, 0, 0, 0, 0, STATUS_IDLE);
      // just outside the deadband, then just inside it
      rows[12] = dir_word(KIND_TICK,  tgt + 128, 0, 0, 0, 0, 0, 0, STATUS_IDLE);
      rows[13] = dir_word(KIND_TICK,  tgt - 127, 0, 0, 1, 0, 1, 0, STATUS_DEADBAND);
      rows[14] = dir_word(KIND_TICK,  0, 0, 0, 0, 0, 0, 0, STATUS_IDLE);
      // braking entry, then no second entry
      rows[15] = dir_word(KIND_START, 0, 0, 0, 0, 0, 0, 0, STATUS_IDLE);
      rows[16] = dir_word(KIND_TICK,  tgt - 200, 0, 0, 0, 0, 0, 0, STATUS_IDLE);
      rows[17] = dir_word(KIND_TICK,  tgt - 300, 0, 0, 0, 0, 0, 0, STATUS_IDLE);
      rows[18] = dir_word(KIND_TICK,  0, 0, 1, 1, 0, 1, 0, STATUS_FAULT);
      // braking entry on a faulting tick
      rows[19] = dir_word(KIND_START, 0, 0, 0, 0, 0, 0, 0, STATUS_IDLE);
      rows[20] = dir_word(KIND_TICK,  tgt + 1000, 0, 1, 1, 0, 1, 0, STATUS_FAULT);
      rows[21] = dir_word(KIND_START, 0, 0, 0, 0, 0, 0, 0, STATUS_IDLE);
      rows[22] = dir_word(KIND_TICK,  0, 0, 0, 0, 0, 0, 0, STATUS_IDLE);
      rows[23] = dir_word(KIND_STOP,  0, 0, 0, 0, 0, 0, 0, STATUS_IDLE);
      rows[24] = dir_word(KIND_TICK,  0, 0, 0, 0, 0, 0, 0, STATUS_IDLE);

      for (i = 0; i < 25; i++) send_word(rows[i]);
      settle();

      // random phases, register extremes first
      for (p = 0; p < 8; p++) begin
         case (p)
            0: begin
               write_csr(CSR_TARGET_POSITION, '0);
               write_csr(CSR_CRUISE_SPEED, DATA_W'(POS_MAX));
               write_csr(CSR_BRAKING_DISTANCE, '0);
               write_csr(CSR_UNMAPPED, DATA_W'($urandom));
            end
            1: begin
               write_csr(CSR_TARGET_POSITION, DATA_W'(POS_MAX));
               write_csr(CSR_CRUISE_SPEED, DATA_W'(POS_MIN));
               write_csr(CSR_BRAKING_DISTANCE, '1);
            end
            2: begin
               write_csr(CSR_TARGET_POSITION, DATA_W'(POS_MIN));
               write_csr(CSR_CRUISE_SPEED, DATA_W'($urandom));
               write_csr(CSR_BRAKING_DISTANCE, DATA_W'($urandom));
            end
            default: begin
               write_csr(CSR_TARGET_POSITION, DATA_W'($urandom));
               write_csr(CSR_CRUISE_SPEED, DATA_W'($urandom));
               if ($urandom_range(0, 1) == 0)
                  write_csr(CSR_BRAKING_DISTANCE, DATA_W'($urandom_range(0, 20000)));
               else
                  write_csr(CSR_BRAKING_DISTANCE, DATA_W'($urandom));
            end
         endcase
         gap_mode = (p % 3 != 0);
         run_phase(PHASE_WORDS);
         settle();
      end

      if (error_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
